// ----- rtl/core/wdre_pkg.sv -----
// Shared types, widths and codes of the windowed drying-rate estimator.
`default_nettype none

package wdre_pkg;

  // Window geometry.
  localparam int unsigned WINDOW = 32;
  localparam int unsigned WIN_AW = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);

  // Field widths.
  localparam int unsigned TS_W      = 32;
  localparam int unsigned LVL_W     = 15;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned MIN_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;

  // Fit arithmetic widths, all exact.
  localparam int unsigned XY_W   = TS_W + LVL_W;
  localparam int unsigned XX_W   = 2 * TS_W;
  localparam int unsigned SX_W   = TS_W + CNT_W;
  localparam int unsigned SY_W   = LVL_W + CNT_W;
  localparam int unsigned SXY_W  = XY_W + CNT_W;
  localparam int unsigned SXX_W  = XX_W + CNT_W;
  localparam int unsigned A_W    = SXY_W + CNT_W;
  localparam int unsigned D_W    = 2 * SX_W;
  localparam int unsigned MAG_W  = A_W;
  localparam int unsigned MAG_LO = 30;
  localparam int unsigned HOUR_W = 22;
  localparam int unsigned NUM_W  = MAG_W + HOUR_W;
  localparam int unsigned QW     = 16;

  localparam int unsigned HOUR_MS   = 3600000;
  localparam int unsigned MINUTE_MS = 60000;
  localparam int unsigned MIN_PER_HOUR = 60;

  localparam logic OPC_READING = 1'b0;
  localparam logic OPC_WATER   = 1'b1;

  localparam logic [RATE_W-1:0] RATE_NEG_SAT = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPRESS   = 3'd0,
    CFG_MIN_POINTS = 3'd1,
    CFG_MIN_SPAN   = 3'd2,
    CFG_MAX_RATE   = 3'd3,
    CFG_CRITICAL   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_NO_DATA = 2'd0,
    ST_COLLECT = 2'd1,
    ST_GAINING = 2'd2,
    ST_ACTIVE  = 2'd3
  } status_e;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN_MINMAX,
    OP_SUM_INIT,
    OP_SCAN_SUM,
    OP_PROD_A,
    OP_PROD_B,
    OP_PROD_C,
    OP_PROD_D,
    OP_PROD_E,
    OP_RATE_DIV,
    OP_RATE_FIN,
    OP_MIN_DIV,
    OP_MIN_FIN,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic need_fit;
    logic need_min;
  } dp_status_t;

  typedef struct packed {
    logic              opcode;
    logic [TS_W-1:0]   timestamp_ms;
    logic [LVL_W-1:0]  moisture;
  } in_item_t;

  typedef struct packed {
    logic                     stored;
    logic [1:0]               status;
    logic [CNT_W-1:0]         sample_count;
    logic                     rate_valid;
    logic signed [RATE_W-1:0] drying_rate;
    logic                     minutes_valid;
    logic [MIN_W-1:0]         minutes_to_critical;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/wdre_div.sv -----
// Iterative divider with a saturating 16-bit quotient, one quotient bit per cycle.
`default_nettype none

module wdre_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wdre_pkg::NUM_W-1:0] num_i,
  input  logic [wdre_pkg::D_W-1:0]   den_i,
  output logic                       done_o,
  output logic [wdre_pkg::QW-1:0]    quot_o
);
  import wdre_pkg::*;

  localparam int unsigned SH_W   = D_W + QW;
  localparam int unsigned STEP_W = $clog2(QW + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  rem_q;
  logic [SH_W-1:0]   dsh_q;
  logic [QW-1:0]     quot_q;
  logic              ge;
  logic [NUM_W-1:0]  diff;

  // Compare the remainder with the shifted divisor.
  assign ge   = SH_W'(rem_q) >= dsh_q;
  assign diff = rem_q - dsh_q[NUM_W-1:0];

  // The first step only checks for a quotient of 2^16 or more.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(QW);
      end else if (busy_q) begin
        if (step_q == STEP_W'(QW) && ge) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
    end
  end

  // Remainder, divisor and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsh_q  <= {den_i, QW'(0)};
      quot_q <= '0;
    end else if (busy_q) begin
      dsh_q <= dsh_q >> 1;
      if (step_q == STEP_W'(QW)) begin
        if (ge) begin
          quot_q <= '1;
        end
      end else begin
        if (ge) begin
          rem_q <= diff;
        end
        quot_q <= {quot_q[QW-2:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- rtl/core/wdre_datapath.sv -----
// Datapath: configuration, window memory, scan accumulators, fit products and divider.
`default_nettype none

module wdre_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wdre_pkg::dp_op_e               op_i,
  input  wdre_pkg::in_item_t             in_item_i,
  input  logic                           cfg_we_i,
  input  logic [wdre_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wdre_pkg::CFG_W-1:0]     cfg_data_i,
  output wdre_pkg::dp_status_t           status_o,
  output wdre_pkg::out_item_t            out_item_o
);
  import wdre_pkg::*;

  // Configuration registers.
  logic [TS_W-1:0]  suppress_q;
  logic [CNT_W-1:0] min_points_q;
  logic [15:0]      min_span_q;
  logic [14:0]      max_rate_q;
  logic [LVL_W-1:0] crit_q;

  // Window state.
  logic [TS_W-1:0]   times_mem  [WINDOW];
  logic [LVL_W-1:0]  levels_mem [WINDOW];
  logic [WIN_AW-1:0] wp_q;
  logic [CNT_W-1:0]  fill_q;
  logic [TS_W-1:0]   water_time_q;
  logic              cool_q;

  // Per-item registers.
  logic             stored_q;
  logic [LVL_W-1:0] lvl_q;

  // Scan pipeline.
  logic [CNT_W-1:0] idx_q;
  logic             rv_q, xv_q, pv_q, first_q;
  logic [TS_W-1:0]  rd_time_q;
  logic [LVL_W-1:0] rd_lvl_q;
  logic [TS_W-1:0]  t0_q, tmax_q;
  logic [TS_W-1:0]  x_q;
  logic [LVL_W-1:0] y_q;
  logic [XY_W-1:0]  xy_q;
  logic [XX_W-1:0]  xx_q;
  logic [SX_W-1:0]  sx_q;
  logic [SY_W-1:0]  sy_q;
  logic [SXY_W-1:0] sxy_q;
  logic [SXX_W-1:0] sxx_q;

  // Fit products.
  logic [A_W-1:0]   a_q, b_q;
  logic [D_W-1:0]   nsxx_q, sxsq_q, d_q;
  logic             pos_q;
  logic [MAG_W-1:0] mag_q;
  logic [NUM_W-1:0] num_q;

  // Results.
  logic                     rate_valid_q;
  logic signed [RATE_W-1:0] rate_q;
  logic [MIN_W-1:0]         minutes_q;
  out_item_t                out_q;

  logic              is_reading, drop, advance, rate_pos, minutes_valid, rate_ok;
  logic [TS_W-1:0]   elapsed, span, span_thr;
  logic [LVL_W-1:0]  gap;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num;
  logic [D_W-1:0]    div_den;
  logic [QW-1:0]     div_quot;
  status_e           status;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      suppress_q   <= TS_W'(600000);
      min_points_q <= CNT_W'(5);
      min_span_q   <= 16'd30;
      max_rate_q   <= 15'd2560;
      crit_q       <= LVL_W'(7680);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SUPPRESS:   suppress_q   <= cfg_data_i;
        CFG_MIN_POINTS: min_points_q <= cfg_data_i[CNT_W-1:0];
        CFG_MIN_SPAN:   min_span_q   <= cfg_data_i[15:0];
        CFG_MAX_RATE:   max_rate_q   <= cfg_data_i[14:0];
        CFG_CRITICAL:   crit_q       <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // A reading inside the cooldown after a watering is dropped.
  assign is_reading = in_item_i.opcode == OPC_READING;
  assign elapsed    = in_item_i.timestamp_ms - water_time_q;
  assign drop       = cool_q && (elapsed < suppress_q);

  // Window control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      fill_q       <= '0;
      water_time_q <= '0;
      cool_q       <= 1'b0;
    end else if (op_i == OP_LOAD) begin
      if (!is_reading) begin
        water_time_q <= in_item_i.timestamp_ms;
        cool_q       <= 1'b1;
      end else if (!drop) begin
        cool_q <= 1'b0;
        wp_q   <= (wp_q == WIN_AW'(WINDOW - 1)) ? '0 : wp_q + WIN_AW'(1);
        if (fill_q < CNT_W'(WINDOW)) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
    end
  end

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD && is_reading && !drop) begin
      times_mem[wp_q]  <= in_item_i.timestamp_ms;
      levels_mem[wp_q] <= in_item_i.moisture;
    end
    rd_time_q <= times_mem[idx_q[WIN_AW-1:0]];
    rd_lvl_q  <= levels_mem[idx_q[WIN_AW-1:0]];
  end

  // Valid entries are always the first fill_q slots of the ring.
  assign advance = idx_q < fill_q;

  // Scan sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      rv_q    <= 1'b0;
      xv_q    <= 1'b0;
      pv_q    <= 1'b0;
      first_q <= 1'b0;
    end else begin
      case (op_i)
        OP_SCAN_INIT, OP_SUM_INIT: begin
          idx_q   <= '0;
          rv_q    <= 1'b0;
          xv_q    <= 1'b0;
          pv_q    <= 1'b0;
          first_q <= 1'b1;
        end
        OP_SCAN_MINMAX: begin
          idx_q <= advance ? idx_q + CNT_W'(1) : idx_q;
          rv_q  <= advance;
          if (rv_q) begin
            first_q <= 1'b0;
          end
        end
        OP_SCAN_SUM: begin
          idx_q <= advance ? idx_q + CNT_W'(1) : idx_q;
          rv_q  <= advance;
          xv_q  <= rv_q;
          pv_q  <= xv_q;
        end
        default: ;
      endcase
    end
  end

  // Oldest and newest time, then the sums over x = t - t0 and y.
  // x and y are summed one stage before their products.
  always_ff @(posedge clk_i) begin
    if (op_i == OP_SCAN_MINMAX && rv_q) begin
      if (first_q || rd_time_q < t0_q) begin
        t0_q <= rd_time_q;
      end
      if (first_q || rd_time_q > tmax_q) begin
        tmax_q <= rd_time_q;
      end
    end
    if (op_i == OP_SUM_INIT) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
    end else if (op_i == OP_SCAN_SUM) begin
      x_q  <= rd_time_q - t0_q;
      y_q  <= rd_lvl_q;
      xy_q <= XY_W'(x_q) * XY_W'(y_q);
      xx_q <= XX_W'(x_q) * XX_W'(x_q);
      if (xv_q) begin
        sx_q <= sx_q + SX_W'(x_q);
        sy_q <= sy_q + SY_W'(y_q);
      end
      if (pv_q) begin
        sxy_q <= sxy_q + SXY_W'(xy_q);
        sxx_q <= sxx_q + SXX_W'(xx_q);
      end
    end
  end

  // Span test without a divide: floor(span / 60000) >= m iff span >= m * 60000.
  assign span     = tmax_q - t0_q;
  assign span_thr = TS_W'(min_span_q) * TS_W'(MINUTE_MS);
  assign rate_ok  = (fill_q >= min_points_q) && (fill_q != '0) && (span >= span_thr);

  // Normal-equation products, split so each multiply has one operand of at most 32 bits.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_PROD_A: begin
        a_q    <= A_W'(fill_q) * A_W'(sxy_q);
        nsxx_q <= D_W'(fill_q) * D_W'(sxx_q);
        sxsq_q <= D_W'(sx_q) * D_W'(sx_q[31:0]);
      end
      OP_PROD_B: begin
        b_q    <= A_W'(sx_q) * A_W'(sy_q);
        sxsq_q <= sxsq_q + ((D_W'(sx_q) * D_W'(sx_q[SX_W-1:32])) << 32);
      end
      OP_PROD_C: begin
        d_q   <= nsxx_q - sxsq_q;
        pos_q <= a_q > b_q;
        mag_q <= (a_q > b_q) ? a_q - b_q : b_q - a_q;
      end
      OP_PROD_D: begin
        num_q <= NUM_W'(mag_q[MAG_LO-1:0]) * NUM_W'(HOUR_MS);
      end
      OP_PROD_E: begin
        num_q <= num_q + ((NUM_W'(mag_q[MAG_W-1:MAG_LO]) * NUM_W'(HOUR_MS)) << MAG_LO);
      end
      default: ;
    endcase
  end

  // The divider serves the rate first and then the minutes.
  assign gap       = lvl_q - crit_q;
  assign div_start = (op_i == OP_RATE_DIV) || (op_i == OP_MIN_DIV);
  assign div_num   = (op_i == OP_RATE_DIV) ? num_q :
                     NUM_W'(gap) * NUM_W'(MIN_PER_HOUR);
  assign div_den   = (op_i == OP_RATE_DIV) ? d_q : D_W'(rate_q[14:0]);

  wdre_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign rate_pos      = !rate_q[RATE_W-1] && (rate_q != '0);
  assign minutes_valid = rate_valid_q && rate_pos;

  // Result registers for the item in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_valid_q <= 1'b0;
      rate_q       <= '0;
      minutes_q    <= '0;
    end else begin
      case (op_i)
        OP_SCAN_INIT: begin
          rate_q    <= '0;
          minutes_q <= '0;
        end
        OP_PROD_A: rate_valid_q <= rate_ok;
        OP_RATE_FIN: begin
          if (pos_q) begin
            rate_q <= (div_quot > 16'd32768) ? RATE_NEG_SAT : ~div_quot + 16'd1;
          end else begin
            rate_q <= (div_quot > 16'(max_rate_q)) ? 16'(max_rate_q) : div_quot;
          end
        end
        OP_MIN_FIN: minutes_q <= div_quot;
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD) begin
      stored_q <= is_reading && !drop;
      lvl_q    <= in_item_i.moisture;
    end
  end

  // Status code.
  always_comb begin
    if (fill_q == '0) begin
      status = ST_NO_DATA;
    end else if (!rate_valid_q) begin
      status = ST_COLLECT;
    end else if (rate_q[RATE_W-1]) begin
      status = ST_GAINING;
    end else begin
      status = ST_ACTIVE;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (op_i == OP_OUT) begin
      out_q.stored              <= stored_q;
      out_q.status              <= status;
      out_q.sample_count        <= fill_q;
      out_q.rate_valid          <= rate_valid_q;
      out_q.drying_rate         <= rate_q;
      out_q.minutes_valid       <= minutes_valid;
      out_q.minutes_to_critical <= minutes_q;
    end
  end

  assign out_item_o = out_q;

  assign status_o.scan_done = (idx_q == fill_q) && !rv_q && !xv_q && !pv_q;
  assign status_o.div_done  = div_done;
  assign status_o.need_fit  = rate_valid_q && (fill_q >= CNT_W'(2)) && (d_q != '0);
  assign status_o.need_min  = minutes_valid && (lvl_q > crit_q);

endmodule

`default_nettype wire

// ----- rtl/core/wdre_ctrl.sv -----
// Controller state machine that sequences the datapath for one item.
`default_nettype none

module wdre_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  wdre_pkg::dp_status_t   status_i,
  output wdre_pkg::dp_op_e       op_o
);
  import wdre_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_INIT,
    S_MINMAX,
    S_SUM_INIT,
    S_SUM,
    S_PA,
    S_PB,
    S_PC,
    S_PD,
    S_PE,
    S_RDIV,
    S_RWAIT,
    S_RFIN,
    S_MCHK,
    S_MDIV,
    S_MWAIT,
    S_MFIN,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, out_valid_q;
  dp_op_e op;

  // Next state and the operation for this cycle.
  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          op      = OP_LOAD;
          state_d = S_SCAN_INIT;
        end
      end
      S_SCAN_INIT: begin
        op      = OP_SCAN_INIT;
        state_d = S_MINMAX;
      end
      S_MINMAX: begin
        op = OP_SCAN_MINMAX;
        if (status_i.scan_done) begin
          state_d = S_SUM_INIT;
        end
      end
      S_SUM_INIT: begin
        op      = OP_SUM_INIT;
        state_d = S_SUM;
      end
      S_SUM: begin
        op = OP_SCAN_SUM;
        if (status_i.scan_done) begin
          state_d = S_PA;
        end
      end
      S_PA: begin
        op      = OP_PROD_A;
        state_d = S_PB;
      end
      S_PB: begin
        op      = OP_PROD_B;
        state_d = S_PC;
      end
      S_PC: begin
        op      = OP_PROD_C;
        state_d = S_PD;
      end
      S_PD: begin
        op      = OP_PROD_D;
        state_d = S_PE;
      end
      S_PE: begin
        op      = OP_PROD_E;
        state_d = status_i.need_fit ? S_RDIV : S_MCHK;
      end
      S_RDIV: begin
        op      = OP_RATE_DIV;
        state_d = S_RWAIT;
      end
      S_RWAIT: begin
        if (status_i.div_done) begin
          state_d = S_RFIN;
        end
      end
      S_RFIN: begin
        op      = OP_RATE_FIN;
        state_d = S_MCHK;
      end
      S_MCHK: begin
        state_d = status_i.need_min ? S_MDIV : S_OUT;
      end
      S_MDIV: begin
        op      = OP_MIN_DIV;
        state_d = S_MWAIT;
      end
      S_MWAIT: begin
        if (status_i.div_done) begin
          state_d = S_MFIN;
        end
      end
      S_MFIN: begin
        op      = OP_MIN_FIN;
        state_d = S_OUT;
      end
      S_OUT: begin
        // Load the output register once the previous result is gone.
        if (!out_valid_q || out_ready_i) begin
          op      = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_ready_q <= state_d == S_IDLE;
      if (op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign op_o        = op;

endmodule

`default_nettype wire

// ----- rtl/core/windowed_drying_rate_estimator.sv -----
// Top level of the windowed drying-rate estimator.
// Each item passes a load, a min/max scan and a sum scan over the n stored readings
// (at most 32), then the product steps and up to two divides before its result is registered.
// The block takes one item at a time; the next item is taken while
// the previous result still waits in the output register.
// Reset: window empty, cooldown clear, registers at their default values.
`default_nettype none

module windowed_drying_rate_estimator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  wdre_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output wdre_pkg::out_item_t            out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wdre_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wdre_pkg::CFG_W-1:0]     cfg_data_i
);
  import wdre_pkg::*;

  dp_op_e     op;
  dp_status_t dp_status;

  // Configuration transactions are always taken.
  assign cfg_ready_o = 1'b1;

  wdre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .op_o        (op)
  );

  wdre_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (dp_status),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/wdre_checker.sv -----
// Port-level assertions for the estimator and the bind that attaches them.
`default_nettype none

module wdre_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input wdre_pkg::out_item_t out_item_o
);
  import wdre_pkg::*;

  // A result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed before its transaction");

  // One item at a time: input is closed right after a transaction.
  a_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input stayed ready after a transaction");

  // The reported count never exceeds the window.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.sample_count <= CNT_W'(WINDOW))
    else $error("sample count beyond window");

  // Minutes are only given with a valid, strictly positive rate.
  a_minutes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.minutes_valid |->
      out_item_o.rate_valid && !out_item_o.drying_rate[RATE_W-1] &&
      (out_item_o.drying_rate != '0))
    else $error("minutes without a positive rate");

  // No-data status matches an empty window.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.status == ST_NO_DATA) == (out_item_o.sample_count == '0)))
    else $error("status and sample count disagree");

endmodule

bind windowed_drying_rate_estimator wdre_checker u_wdre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
